@@ src/pmvd_pkg.sv @@
`timescale 1ns / 1ps

package pmvd_pkg;

  // Band code and voted-mode encoding
  typedef enum logic [1:0] {
    MODE_IR   = 2'd0,
    MODE_VI   = 2'd1,
    MODE_FUSE = 2'd2
  } mode_e;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned BAND_W     = 16;
  localparam int unsigned THR_W      = 5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_FLOOR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IR_VI_SPLIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VI_FUSE_SPLIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_CEILING  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VOTE_THRESH   = 3'd4;

  // Register reset values
  localparam logic [BAND_W-1:0] BAND_FLOOR_RST    = 16'd800;
  localparam logic [BAND_W-1:0] IR_VI_SPLIT_RST   = 16'd1200;
  localparam logic [BAND_W-1:0] VI_FUSE_SPLIT_RST = 16'd1600;
  localparam logic [BAND_W-1:0] BAND_CEILING_RST  = 16'd2100;
  localparam logic [THR_W-1:0]  VOTE_THRESH_RST   = 5'd6;

  // Per-mode vote counters wrap at four bits
  localparam int unsigned CNT_W = 4;

  // Band limits handed to the width classifier
  typedef struct packed {
    logic [BAND_W-1:0] floor_lvl;
    logic [BAND_W-1:0] ir_vi;
    logic [BAND_W-1:0] vi_fuse;
    logic [BAND_W-1:0] ceiling;
  } bands_t;

  // Outcome of one tick of pulse measurement
  typedef struct packed {
    logic  accepted;
    mode_e code;
  } pulse_t;

endpackage

@@ src/pmvd_if.sv @@
`timescale 1ns / 1ps

// Pin sample channel
interface pmvd_in_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink   (input valid, input pin_level, output ready);
endinterface

// Decoded result channel
interface pmvd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] current_mode;
  logic       pulse_accepted;
  logic [1:0] pulse_code;

  modport source (output valid, output current_mode, output pulse_accepted,
                  output pulse_code, input ready);
  modport sink   (input valid, input current_mode, input pulse_accepted,
                  input pulse_code, output ready);
endinterface

@@ src/pmvd_width_meas.sv @@
`timescale 1ns / 1ps

module pmvd_width_meas import pmvd_pkg::*; #(
  parameter int unsigned WIDTH_BITS = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   step_i,
  input  logic   level_i,
  input  bands_t bands_i,
  output pulse_t pulse_o
);

  localparam int unsigned CmpW = (WIDTH_BITS > BAND_W) ? WIDTH_BITS : BAND_W;
  localparam logic [WIDTH_BITS-1:0] WidthMax = {WIDTH_BITS{1'b1}};

  logic                  prev_level_q, prev_level_d;
  logic                  in_pulse_q, in_pulse_d;
  logic [WIDTH_BITS-1:0] width_q, width_d;

  logic [CmpW-1:0] w_ext, floor_ext, ir_vi_ext, vi_fuse_ext, ceil_ext;
  logic            hit_ir, hit_vi, hit_fuse;
  logic            falling;

  // Zero-extend width and limits to a common compare width
  assign w_ext       = CmpW'(width_q);
  assign floor_ext   = CmpW'(bands_i.floor_lvl);
  assign ir_vi_ext   = CmpW'(bands_i.ir_vi);
  assign vi_fuse_ext = CmpW'(bands_i.vi_fuse);
  assign ceil_ext    = CmpW'(bands_i.ceiling);

  assign hit_ir   = (w_ext > floor_ext)   && (w_ext <= ir_vi_ext);
  assign hit_vi   = (w_ext > ir_vi_ext)   && (w_ext <= vi_fuse_ext);
  assign hit_fuse = (w_ext > vi_fuse_ext) && (w_ext <= ceil_ext);

  assign falling = !level_i && prev_level_q && in_pulse_q;

  // Edge detect, saturating width count, band sort on the falling edge
  always_comb begin
    prev_level_d     = level_i;
    in_pulse_d       = in_pulse_q;
    width_d          = width_q;
    pulse_o.accepted = 1'b0;
    pulse_o.code     = MODE_IR;
    if (level_i && !prev_level_q) begin
      in_pulse_d = 1'b1;
      width_d    = WIDTH_BITS'(1);
    end else if (level_i && in_pulse_q) begin
      if (width_q != WidthMax) begin
        width_d = width_q + WIDTH_BITS'(1);
      end
    end else if (falling) begin
      in_pulse_d = 1'b0;
      if (hit_ir) begin
        pulse_o.accepted = 1'b1;
        pulse_o.code     = MODE_IR;
      end else if (hit_vi) begin
        pulse_o.accepted = 1'b1;
        pulse_o.code     = MODE_VI;
      end else if (hit_fuse) begin
        pulse_o.accepted = 1'b1;
        pulse_o.code     = MODE_FUSE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_level_q <= 1'b0;
      in_pulse_q   <= 1'b0;
      width_q      <= '0;
    end else if (step_i) begin
      prev_level_q <= prev_level_d;
      in_pulse_q   <= in_pulse_d;
      width_q      <= width_d;
    end
  end

  // A band hit only ever comes from a measured pulse ending on this tick
  a_accept_on_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pulse_o.accepted |-> (falling && prev_level_q && !level_i))
    else $error("pulse accepted without a falling edge");

endmodule

@@ src/pmvd_vote.sv @@
`timescale 1ns / 1ps

module pmvd_vote import pmvd_pkg::*; #(
  parameter int unsigned WINDOW_LEN = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mode_e            code_i,
  input  logic [THR_W-1:0] thresh_i,
  output mode_e            mode_d_o
);

  localparam logic [CNT_W-1:0] CntInit = CNT_W'(WINDOW_LEN);

  mode_e            win_q [WINDOW_LEN];
  logic [CNT_W-1:0] ir_cnt_q, vi_cnt_q, fuse_cnt_q;
  logic [CNT_W-1:0] ir_cnt_d, vi_cnt_d, fuse_cnt_d;
  mode_e            mode_q, mode_d;
  mode_e            oldest;

  assign oldest = win_q[0];

  // Count in the new code, count out the one leaving the window
  always_comb begin
    ir_cnt_d   = ir_cnt_q   + CNT_W'(code_i == MODE_IR)   - CNT_W'(oldest == MODE_IR);
    vi_cnt_d   = vi_cnt_q   + CNT_W'(code_i == MODE_VI)   - CNT_W'(oldest == MODE_VI);
    fuse_cnt_d = fuse_cnt_q + CNT_W'(code_i == MODE_FUSE) - CNT_W'(oldest == MODE_FUSE);
  end

  // Last mode in IR, VI, Fuse order that meets the threshold wins
  always_comb begin
    mode_d = mode_q;
    if (push_i) begin
      if (THR_W'(ir_cnt_d) >= thresh_i) begin
        mode_d = MODE_IR;
      end
      if (THR_W'(vi_cnt_d) >= thresh_i) begin
        mode_d = MODE_VI;
      end
      if (THR_W'(fuse_cnt_d) >= thresh_i) begin
        mode_d = MODE_FUSE;
      end
    end
  end

  assign mode_d_o = mode_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_q[i] <= MODE_IR;
      end
      ir_cnt_q   <= CntInit;
      vi_cnt_q   <= '0;
      fuse_cnt_q <= '0;
      mode_q     <= MODE_IR;
    end else if (push_i) begin
      for (int i = 0; i + 1 < WINDOW_LEN; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WINDOW_LEN-1] <= code_i;
      ir_cnt_q   <= ir_cnt_d;
      vi_cnt_q   <= vi_cnt_d;
      fuse_cnt_q <= fuse_cnt_d;
      mode_q     <= mode_d;
    end
  end

  // Counters always account for every window slot
  a_cnt_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, ir_cnt_q} + {1'b0, vi_cnt_q} + {1'b0, fuse_cnt_q}) == (CNT_W + 1)'(WINDOW_LEN))
    else $error("vote counters do not sum to window length");

  // Voted mode only moves on a push
  a_mode_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !push_i |=> $stable(mode_q))
    else $error("voted mode changed without a new code");

  // Adopted mode must actually meet the threshold
  a_mode_met: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && (mode_d != mode_q)) |->
      ((mode_d == MODE_IR   && THR_W'(ir_cnt_d)   >= thresh_i) ||
       (mode_d == MODE_VI   && THR_W'(vi_cnt_d)   >= thresh_i) ||
       (mode_d == MODE_FUSE && THR_W'(fuse_cnt_d) >= thresh_i)))
    else $error("mode adopted below threshold");

endmodule

@@ src/pwm_pulse_mode_vote_decoder.sv @@
`timescale 1ns / 1ps

// An accepted pin sample passes through the input register, then the result
// register, before its result beat appears on out_o.
// Throughput: one sample per cycle while results drain; both registers move
// together, so while a result waits only an empty input register takes a beat.
// Reset (rst_ni, async, low): band registers return to 800/1200/1600/2100,
// threshold 6, window full of IR, voted mode IR, no pulse in progress.
module pwm_pulse_mode_vote_decoder import pmvd_pkg::*; #(
  parameter int unsigned WINDOW_LEN = 10,
  parameter int unsigned WIDTH_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  pmvd_in_if.sink               in_i,
  pmvd_out_if.source            out_o
);

  logic             in_valid_q;
  logic             level_q;
  logic             out_valid_q;
  logic [1:0]       mode_q;
  logic             acc_q;
  logic [1:0]       code_q;
  logic             advance;
  logic             step;
  bands_t           bands_q;
  logic [THR_W-1:0] thresh_q;
  pulse_t           pulse;
  mode_e            mode_next;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bands_q.floor_lvl <= BAND_FLOOR_RST;
      bands_q.ir_vi     <= IR_VI_SPLIT_RST;
      bands_q.vi_fuse   <= VI_FUSE_SPLIT_RST;
      bands_q.ceiling   <= BAND_CEILING_RST;
      thresh_q          <= VOTE_THRESH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BAND_FLOOR:    bands_q.floor_lvl <= cfg_data_i;
        CFG_IR_VI_SPLIT:   bands_q.ir_vi     <= cfg_data_i;
        CFG_VI_FUSE_SPLIT: bands_q.vi_fuse   <= cfg_data_i;
        CFG_BAND_CEILING:  bands_q.ceiling   <= cfg_data_i;
        CFG_VOTE_THRESH:   thresh_q          <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow: both stages move when the result slot is free or drained
  assign advance    = !out_valid_q || out_o.ready;
  assign step       = advance && in_valid_q;
  assign in_i.ready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready) begin
      level_q <= in_i.pin_level;
    end
  end

  pmvd_width_meas #(
    .WIDTH_BITS (WIDTH_BITS)
  ) u_width (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .level_i (level_q),
    .bands_i (bands_q),
    .pulse_o (pulse)
  );

  pmvd_vote #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_vote (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (step && pulse.accepted),
    .code_i   (pulse.code),
    .thresh_i (thresh_q),
    .mode_d_o (mode_next)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      mode_q <= mode_next;
      acc_q  <= pulse.accepted;
      code_q <= pulse.code;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.current_mode   = mode_q;
  assign out_o.pulse_accepted = acc_q;
  assign out_o.pulse_code     = code_q;

endmodule

@@ sim/pwm_pulse_mode_vote_decoder_tb.sv @@
`timescale 1ns / 1ps

module pwm_pulse_mode_vote_decoder_tb;
  import pmvd_pkg::*;

  localparam int unsigned WIN_LEN      = 10;
  localparam int unsigned PW_BITS      = 16;
  localparam logic [PW_BITS-1:0] PW_MAX = '1;
  localparam int unsigned PIPE_LAT     = 2;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned DRAIN_LIMIT  = 100000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned NUM_RANDOM   = 700;
  localparam int unsigned NUM_PHASES   = 5;
  localparam int unsigned CFG_IDX_LAST = (1 << CFG_IDX_W) - 1;

  // One expected result beat
  typedef struct packed {
    mode_e mode;
    logic  accepted;
    mode_e code;
  } tick_res_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  pmvd_in_if  pin_ch ();
  pmvd_out_if res_ch ();

  pwm_pulse_mode_vote_decoder #(
    .WINDOW_LEN(WIN_LEN),
    .WIDTH_BITS(PW_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (pin_ch),
    .out_o      (res_ch)
  );

  always #1 clk_i = ~clk_i;

  // Decoder model state
  bands_t             mdl_bands;
  logic [THR_W-1:0]   mdl_thresh;
  logic               mdl_prev_lvl;
  logic               mdl_in_pulse;
  logic [PW_BITS-1:0] mdl_width;
  mode_e              mdl_window [WIN_LEN];
  logic [CNT_W-1:0]   mdl_votes [3];
  mode_e              mdl_mode;

  tick_res_t expected_ticks [$];

  int unsigned mismatches   = 0;
  int unsigned n_sent       = 0;
  int unsigned n_results    = 0;
  int unsigned n_pulses     = 0;
  int unsigned n_mode_flips = 0;
  int unsigned n_cfg_writes = 0;
  mode_e       last_mode    = MODE_IR;

  // Sender burst state
  int unsigned burst_left = 0;
  bit          tx_steady  = 1'b0;

  // Receiver stall pattern and long hold-off
  logic [15:0] rx_pat   = '1;
  logic [5:0]  rx_tick  = '0;
  int unsigned hold_cnt = 0;

  function automatic void model_reset();
    mdl_bands    = '{floor_lvl: BAND_FLOOR_RST, ir_vi: IR_VI_SPLIT_RST,
                     vi_fuse: VI_FUSE_SPLIT_RST, ceiling: BAND_CEILING_RST};
    mdl_thresh   = VOTE_THRESH_RST;
    mdl_prev_lvl = 1'b0;
    mdl_in_pulse = 1'b0;
    mdl_width    = '0;
    foreach (mdl_window[i]) mdl_window[i] = MODE_IR;
    mdl_votes[MODE_IR]   = CNT_W'(WIN_LEN);
    mdl_votes[MODE_VI]   = '0;
    mdl_votes[MODE_FUSE] = '0;
    mdl_mode     = MODE_IR;
  endfunction

  function automatic bit width_in_band(logic [PW_BITS-1:0] w, logic [BAND_W-1:0] lo,
                                       logic [BAND_W-1:0] hi);
    return (w > lo) && (w <= hi);
  endfunction

  // Advance the model by one pin sample and return the beat it produces
  function automatic tick_res_t decode_tick(logic lvl);
    tick_res_t r;
    mode_e     oldest;
    int        i;
    r = '{mode: MODE_IR, accepted: 1'b0, code: MODE_IR};
    if (lvl && !mdl_prev_lvl) begin
      mdl_in_pulse = 1'b1;
      mdl_width    = PW_BITS'(1);
    end else if (lvl && mdl_in_pulse) begin
      if (mdl_width != PW_MAX) mdl_width = mdl_width + 1'b1;
    end else if (!lvl && mdl_prev_lvl && mdl_in_pulse) begin
      mdl_in_pulse = 1'b0;
      // first matching band wins
      if (width_in_band(mdl_width, mdl_bands.floor_lvl, mdl_bands.ir_vi)) begin
        r.accepted = 1'b1;
        r.code     = MODE_IR;
      end else if (width_in_band(mdl_width, mdl_bands.ir_vi, mdl_bands.vi_fuse)) begin
        r.accepted = 1'b1;
        r.code     = MODE_VI;
      end else if (width_in_band(mdl_width, mdl_bands.vi_fuse, mdl_bands.ceiling)) begin
        r.accepted = 1'b1;
        r.code     = MODE_FUSE;
      end
      // slide the window and re-vote, later modes take priority
      if (r.accepted) begin
        oldest = mdl_window[0];
        mdl_votes[r.code] = mdl_votes[r.code] + 1'b1;
        mdl_votes[oldest] = mdl_votes[oldest] - 1'b1;
        for (i = 0; i + 1 < WIN_LEN; i++) mdl_window[i] = mdl_window[i+1];
        mdl_window[WIN_LEN-1] = r.code;
        if (mdl_votes[MODE_IR] >= mdl_thresh) mdl_mode = MODE_IR;
        if (mdl_votes[MODE_VI] >= mdl_thresh) mdl_mode = MODE_VI;
        if (mdl_votes[MODE_FUSE] >= mdl_thresh) mdl_mode = MODE_FUSE;
      end
    end
    mdl_prev_lvl = lvl;
    r.mode = mdl_mode;
    return r;
  endfunction

  function automatic void report_mismatch(string what, tick_res_t want, logic [1:0] mode,
                                          logic acc, logic [1:0] code);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t %s: expected mode=%0d acc=%0b code=%0d, got mode=%0d acc=%0b code=%0d",
               $time, what, want.mode, want.accepted, want.code, mode, acc, code);
  endfunction

  // Result check first, then prediction for the beat taken at this edge
  always @(posedge clk_i) begin
    tick_res_t want;
    if (res_ch.valid && res_ch.ready) begin
      n_results++;
      if (expected_ticks.size() == 0) begin
        report_mismatch("unexpected beat", '0, res_ch.current_mode, res_ch.pulse_accepted,
                        res_ch.pulse_code);
      end else begin
        want = expected_ticks.pop_front();
        if (res_ch.current_mode !== want.mode || res_ch.pulse_accepted !== want.accepted ||
            res_ch.pulse_code !== want.code)
          report_mismatch("mismatch", want, res_ch.current_mode, res_ch.pulse_accepted,
                          res_ch.pulse_code);
        if (want.accepted) n_pulses++;
        if (want.mode != last_mode) n_mode_flips++;
        last_mode = want.mode;
      end
    end
    if (pin_ch.valid && pin_ch.ready) expected_ticks.push_back(decode_tick(pin_ch.pin_level));
  end

  // Receiver: rotating stall pattern, reloaded whenever rx_tick wraps, some all-ready
  always @(posedge clk_i) begin
    if (rx_tick == '0)
      rx_pat <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0101);
    else
      rx_pat <= {rx_pat[0], rx_pat[15:1]};
    rx_tick      <= rx_tick + 1'b1;
    res_ch.ready <= rx_pat[0] && (hold_cnt == 0);
  end

  // Long receiver hold-off countdown
  always @(posedge clk_i) begin
    if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
  end

  // Drive one pin sample beat, opening a new burst after a random, possibly empty, gap
  task automatic send_level(logic lvl);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = tx_steady ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
      if (gap != 0) begin
        pin_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    pin_ch.valid     <= 1'b1;
    pin_ch.pin_level <= lvl;
    do @(posedge clk_i); while (!pin_ch.ready);
    burst_left--;
    n_sent++;
  endtask

  task automatic send_pulse(int unsigned high_len, int unsigned low_len);
    repeat (high_len) send_level(1'b1);
    repeat (low_len) send_level(1'b0);
  endtask

  // Wait until every expected beat has come back, then let the pipe go quiet
  task automatic settle();
    int unsigned guard;
    guard = 0;
    pin_ch.valid <= 1'b0;
    // let the monitor queue the last accepted beat first
    @(posedge clk_i);
    while (expected_ticks.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (PIPE_LAT + 2) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_BAND_FLOOR:    mdl_bands.floor_lvl = data;
      CFG_IR_VI_SPLIT:   mdl_bands.ir_vi     = data;
      CFG_VI_FUSE_SPLIT: mdl_bands.vi_fuse   = data;
      CFG_BAND_CEILING:  mdl_bands.ceiling   = data;
      CFG_VOTE_THRESH:   mdl_thresh          = data[THR_W-1:0];
      default: ;
    endcase
    n_cfg_writes++;
    @(posedge clk_i);
  endtask

  task automatic set_bands(logic [BAND_W-1:0] lo, logic [BAND_W-1:0] ir_vi,
                           logic [BAND_W-1:0] vi_fuse, logic [BAND_W-1:0] hi);
    cfg_write(CFG_BAND_FLOOR, lo);
    cfg_write(CFG_IR_VI_SPLIT, ir_vi);
    cfg_write(CFG_VI_FUSE_SPLIT, vi_fuse);
    cfg_write(CFG_BAND_CEILING, hi);
  endtask

  // Mostly well-formed pulses sized around the bands, some random noise
  task automatic send_random_traffic(int unsigned count, int unsigned max_high);
    int unsigned target;
    target = n_sent + count;
    while (n_sent < target) begin
      if ($urandom_range(0, 4) != 0)
        send_pulse($urandom_range(1, max_high), $urandom_range(1, 3));
      else
        repeat ($urandom_range(1, 8)) send_level(1'($urandom_range(0, 1)));
    end
  endtask

  // Pin high on the very first sample counts as a rising edge; reset threshold
  // of six switches to VI on the sixth VI pulse
  task automatic test_high_at_reset();
    set_bands(16'd0, 16'd2, 16'd4, 16'd8);
    repeat (6) send_pulse(3, 1);
    settle();
  endtask

  // Widths on both sides of every band edge
  task automatic test_band_edges();
    set_bands(16'd2, 16'd4, 16'd6, 16'd8);
    cfg_write(CFG_VOTE_THRESH, 16'd2);
    for (int unsigned w = 1; w <= 9; w++) send_pulse(w, 1);
    settle();
  endtask

  // Bands whose lower bound is not below the upper one match nothing
  task automatic test_misordered_bands();
    set_bands(16'd5, 16'd3, 16'd3, 16'd6);
    cfg_write(CFG_VOTE_THRESH, 16'd1);
    for (int unsigned w = 3; w <= 7; w++) send_pulse(w, 1);
    settle();
    set_bands(16'd4, 16'd4, 16'd4, 16'd4);
    send_pulse(4, 1);
    send_pulse(5, 1);
    settle();
    set_bands(16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
    send_pulse(1, 1);
    send_pulse(2, 2);
    settle();
  endtask

  // Threshold masked to zero, unreachable thresholds, full window, spare indexes
  task automatic test_threshold_extremes();
    int unsigned k;
    set_bands(16'd0, 16'd2, 16'd4, 16'd8);
    cfg_write(CFG_VOTE_THRESH, 16'hFFE0);
    send_pulse(1, 1);
    settle();
    cfg_write(CFG_VOTE_THRESH, 16'h001F);
    repeat (3) send_pulse(3, 1);
    settle();
    cfg_write(CFG_VOTE_THRESH, 16'd16);
    repeat (2) send_pulse(1, 1);
    settle();
    cfg_write(CFG_VOTE_THRESH, 16'(WIN_LEN));
    for (k = CFG_VOTE_THRESH + 1; k <= CFG_IDX_LAST; k++) cfg_write(CFG_IDX_W'(k), 16'd0);
    repeat (WIN_LEN) send_pulse(3, 1);
    settle();
  endtask

  // Receiver stops for a long stretch while samples keep coming
  task automatic test_backpressure();
    set_bands(16'd1, 16'd3, 16'd5, 16'd7);
    cfg_write(CFG_VOTE_THRESH, 16'd3);
    tx_steady = 1'b1;
    hold_cnt <= HOLD_CYCLES;
    send_random_traffic(60, 9);
    tx_steady = 1'b0;
    settle();
  endtask

  // Random settings per phase; first and last phases pin the extremes
  task automatic test_random();
    logic [BAND_W-1:0] lo, a, b, c, t;
    logic [THR_W-1:0]  thr;
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      lo = (ph == 0) ? 16'd0 : 16'($urandom_range(0, 3));
      a  = lo + 16'($urandom_range(0, 4));
      b  = a + 16'($urandom_range(0, 4));
      c  = b + 16'($urandom_range(0, 5));
      if ($urandom_range(0, 4) == 0) begin
        t = a;
        a = b;
        b = t;
      end
      if (ph == 0) thr = 5'd1;
      else if (ph == NUM_PHASES - 1) thr = 5'(WIN_LEN);
      else thr = 5'($urandom_range(1, WIN_LEN));
      set_bands(lo, a, b, c);
      cfg_write(CFG_VOTE_THRESH, 16'(thr));
      send_random_traffic(NUM_RANDOM / NUM_PHASES, int'(c) + 2);
      settle();
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_data_i       = '0;
    pin_ch.valid     = 1'b0;
    pin_ch.pin_level = 1'b0;
    res_ch.ready     = 1'b0;
    model_reset();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_high_at_reset();
    test_band_edges();
    test_misordered_bands();
    test_threshold_extremes();
    test_backpressure();
    test_random();

    settle();
    if (expected_ticks.size() != 0) begin
      $display("%0d expected beats never arrived", expected_ticks.size());
      mismatches += expected_ticks.size();
    end
    $display("Sent %0d pin samples through %0d register writes; checked %0d result beats.",
             n_sent, n_cfg_writes, n_results);
    $display("Saw %0d in-band pulses and %0d voted-mode changes; %0d mismatches.",
             n_pulses, n_mode_flips, mismatches);
    if (mismatches == 0) begin
      $display("pwm_pulse_mode_vote_decoder test passed");
    end else begin
      $display("pwm_pulse_mode_vote_decoder test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("pwm_pulse_mode_vote_decoder test failed");
    $finish;
  end

endmodule
